>>> rtl/mpid_pkg.sv
// shared types, constants and microcode rom for the multichannel pid core
package mpid_pkg;

	localparam int DATA_W    = 32;
	localparam int REG_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 66;
	localparam int STEP_W    = 4;
	localparam int UC_LEN    = 14;
	localparam int DIV_W     = 7;
	localparam logic [DIV_W-1:0] DIV_STEPS = 7'd64;

	typedef logic signed [DATA_W-1:0] word_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAU   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ILIM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OLIM  = 3'd6;

	// register reset values
	localparam logic [REG_W-1:0] RST_KP   = 31'd415034;
	localparam logic [REG_W-1:0] RST_KI   = 31'd7518303;
	localparam logic [REG_W-1:0] RST_KD   = 31'd0;
	localparam logic [REG_W-1:0] RST_TAU  = 31'd0;
	localparam logic [REG_W-1:0] RST_TS   = 31'd1088;
	localparam logic [REG_W-1:0] RST_ILIM = 31'd5242880;
	localparam logic [REG_W-1:0] RST_OLIM = 31'd3276800;

	// plant coefficients, unsigned q0.16
	localparam logic [15:0] PLANT_B0 = 16'd1877;
	localparam logic [15:0] PLANT_B1 = 16'd1874;
	localparam logic [15:0] PLANT_A1 = 16'd48950;

	typedef enum logic [3:0] {
		OP_NOP, OP_PREP, OP_KT, OP_P, OP_INTEG, OP_MA, OP_NUM, OP_DIV,
		OP_D, OP_U, OP_ACC_LOAD, OP_ACC_ADD, OP_Y
	} op_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_KI_T, MUL_KP_ERR, MUL_KT_AVG, MUL_KD_DM, MUL_C2_DP,
		MUL_B1_LU, MUL_A1_LY, MUL_B0_U
	} mul_t;

	typedef enum logic [1:0] {
		SEQ_NEXT, SEQ_HOLD_DIV, SEQ_DONE
	} seq_t;

	typedef struct packed {
		op_t  op;
		mul_t mul;
		seq_t seq;
	} ctrl_t;

	typedef struct packed {
		word_t last_err;
		word_t integ;
		word_t dterm;
		word_t last_meas;
		word_t last_drive;
		word_t last_plant;
	} chan_state_t;

	// one control word per step; op consumes the product issued the step before
	function automatic ctrl_t uc_rom(input logic [STEP_W-1:0] addr);
		ctrl_t cw;
		case (addr)
			4'd0:    cw = '{OP_PREP,     MUL_KI_T,   SEQ_NEXT};
			4'd1:    cw = '{OP_KT,       MUL_KP_ERR, SEQ_NEXT};
			4'd2:    cw = '{OP_P,        MUL_KT_AVG, SEQ_NEXT};
			4'd3:    cw = '{OP_INTEG,    MUL_KD_DM,  SEQ_NEXT};
			4'd4:    cw = '{OP_MA,       MUL_C2_DP,  SEQ_NEXT};
			4'd5:    cw = '{OP_NUM,      MUL_NONE,   SEQ_NEXT};
			4'd6:    cw = '{OP_DIV,      MUL_B1_LU,  SEQ_NEXT};
			4'd7:    cw = '{OP_ACC_LOAD, MUL_A1_LY,  SEQ_NEXT};
			4'd8:    cw = '{OP_ACC_ADD,  MUL_NONE,   SEQ_NEXT};
			4'd9:    cw = '{OP_NOP,      MUL_NONE,   SEQ_HOLD_DIV};
			4'd10:   cw = '{OP_D,        MUL_NONE,   SEQ_NEXT};
			4'd11:   cw = '{OP_U,        MUL_NONE,   SEQ_NEXT};
			4'd12:   cw = '{OP_NOP,      MUL_B0_U,   SEQ_NEXT};
			// keep the b0 product alive while the result beat waits
			4'd13:   cw = '{OP_Y,        MUL_B0_U,   SEQ_DONE};
			default: cw = '{OP_NOP,      MUL_NONE,   SEQ_DONE};
		endcase
		return cw;
	endfunction

endpackage

>>> rtl/multichannel_pid_with_plant_model_core.sv
// multichannel pid controller with first-order plant model, microcoded datapath
// one beat in flight: a new input beat is taken only after the last result beat is loaded,
// so the radix-2 divider of the derivative filter bounds the beat rate;
//   a stalled output holds the sequencer further
// a beat for a channel at or above NUM_CHANNELS is taken with no result
// reset: registers return to defaults, per-channel valid bits clear so state reads zero
module multichannel_pid_with_plant_model_core #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [mpid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpid_pkg::REG_W-1:0]          cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          channel,
	input  mpid_pkg::word_t                     setpoint,
	input  mpid_pkg::word_t                     measurement,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output mpid_pkg::word_t                     plant_output,
	output mpid_pkg::word_t                     drive_value
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PW   = mpid_pkg::PROD_W;
	localparam int RW   = mpid_pkg::REG_W;
	localparam logic signed [PW-1:0] W_MAX = 66'sd2147483647;
	localparam logic signed [PW-1:0] W_MIN = -66'sd2147483648;

	// rounding shift by 16, half away from zero
	function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = v + 66'sd32768;
		if (v[PW-1])
			t = t - 66'sd1;
		return t >>> 16;
	endfunction

	function automatic mpid_pkg::word_t sat32(input logic signed [PW-1:0] v);
		mpid_pkg::word_t r;
		if (v > W_MAX)
			r = W_MAX[31:0];
		else if (v < W_MIN)
			r = W_MIN[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic mpid_pkg::word_t clamp_sym(input logic signed [PW-1:0] v,
			input logic [RW-1:0] lim);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		mpid_pkg::word_t r;
		hi = $signed({35'd0, lim});
		lo = -hi;
		if (v > hi)
			r = hi[31:0];
		else if (v < lo)
			r = lo[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

	// configuration registers
	logic [RW-1:0] kp_q, ki_q, kd_q, tau_q, ts_q, ilim_q, olim_q;

	// sequencer
	logic                            busy_q;
	logic [mpid_pkg::STEP_W-1:0]     step_q;
	mpid_pkg::ctrl_t                 cw;
	logic                            accept;
	logic                            ch_ok;
	logic [CH_W-1:0]                 idx;
	logic                            out_free;
	logic                            fire_y;
	logic                            div_load;
	logic                            div_busy;

	// channel state memory with per-entry valid bits
	mpid_pkg::chan_state_t           st_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]         vld_q;
	mpid_pkg::chan_state_t           st_rd_q;
	logic                            vld_rd_q;
	mpid_pkg::chan_state_t           st;

	// working registers
	logic [CH_W-1:0]                 ch_idx_q;
	mpid_pkg::word_t                 sp_q, ms_q;
	mpid_pkg::word_t                 err_q, dm_q, avg_q, p_q, integ_q, d_q, u_q;
	logic signed [33:0]              c2_q;
	logic [32:0]                     den_q;
	logic [RW-1:0]                   kt_q;
	logic [31:0]                     dm_mag_q, c2_mag_q, dp_mag_q;
	logic [63:0]                     ma_q, num_q;
	logic                            nn_q;
	logic signed [49:0]              acc_q;
	logic signed [PW-1:0]            prod_q;
	logic signed [32:0]              mul_a, mul_b;

	// divider
	logic [mpid_pkg::DIV_W-1:0]      div_cnt_q;
	logic [63:0]                     quo_q;
	logic [32:0]                     rem_q;
	logic [33:0]                     div_shift;
	logic [34:0]                     div_trial;

	// output registers
	logic                            out_valid_q;
	mpid_pkg::word_t                 plant_q, drive_q;

	// combinational results
	logic [RW-1:0]                   t_eff;
	mpid_pkg::word_t                 err_c, dm_c, p_c, integ_c, d_c, u_c, y_c, kt_full;
	logic signed [33:0]              c2_c;
	logic [32:0]                     den_c;
	logic signed [PW-1:0]            rnd_c;
	logic signed [33:0]              avg_sum, avg_rnd;
	logic [31:0]                     dm_mag_c, c2_mag_c, dp_mag_c;
	logic [63:0]                     mb_c, num_c, dividend_c;
	logic                            nn_c, na_c, nb_c, q_big;

	assign cw        = mpid_pkg::uc_rom(step_q);
	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign ch_ok     = 32'(channel) < NUM_CHANNELS;
	assign idx       = CH_W'(channel);
	assign out_free  = !out_valid_q || out_ready;
	assign fire_y    = busy_q && (cw.op == mpid_pkg::OP_Y) && out_free;
	assign div_load  = busy_q && (cw.op == mpid_pkg::OP_DIV);
	assign div_busy  = div_cnt_q != '0;

	assign out_valid    = out_valid_q;
	assign plant_output = plant_q;
	assign drive_value  = drive_q;

	// never-written channels read as zero state
	assign st = vld_rd_q ? st_rd_q : '0;

	always_comb begin
		t_eff   = (ts_q == '0) ? 31'd1 : ts_q;
		err_c   = sat32(PW'(sp_q) - PW'(ms_q));
		dm_c    = sat32(PW'(ms_q) - PW'(st.last_meas));
		c2_c    = $signed({2'b00, tau_q, 1'b0}) - $signed({3'b000, t_eff});
		den_c   = {1'b0, tau_q, 1'b0} + {2'b00, t_eff};
		rnd_c   = rnd16(prod_q);
		kt_full = sat32(rnd_c);
		p_c     = sat32(rnd_c);
		integ_c = clamp_sym(rnd_c + PW'(st.integ), ilim_q);

		// mean of error pair, rounded half away from zero
		avg_sum = 34'(err_q) + 34'(st.last_err);
		avg_rnd = avg_sum + (avg_sum[33] ? 34'sd0 : 34'sd1);

		dm_mag_c = dm_q[31] ? (32'd0 - dm_q) : dm_q;
		c2_mag_c = c2_q[33] ? 32'(34'sd0 - c2_q) : c2_q[31:0];
		dp_mag_c = st.dterm[31] ? (32'd0 - st.dterm) : st.dterm;

		// derivative numerator as sign and magnitude
		mb_c = prod_q[63:0];
		na_c = dm_q[31];
		nb_c = c2_q[33] ^ st.dterm[31];
		if (na_c == nb_c) begin
			num_c = ma_q + mb_c;
			nn_c  = na_c;
		end else if (ma_q >= mb_c) begin
			num_c = ma_q - mb_c;
			nn_c  = na_c;
		end else begin
			num_c = mb_c - ma_q;
			nn_c  = nb_c;
		end
		dividend_c = num_q + {32'd0, den_q[32:1]};

		// quotient to signed drive term, leading minus folded into the sign
		q_big = |quo_q[63:31];
		if (quo_q == '0)
			d_c = '0;
		else if (!nn_q)
			d_c = q_big ? W_MIN[31:0] : (32'd0 - quo_q[31:0]);
		else
			d_c = q_big ? W_MAX[31:0] : quo_q[31:0];

		u_c = clamp_sym(PW'(p_q) + PW'(integ_q) + PW'(d_q), olim_q);
		y_c = sat32(rnd16(PW'(acc_q) + prod_q));

		// restoring divider trial subtract
		div_shift = {rem_q, quo_q[63]};
		div_trial = {1'b0, div_shift} - {2'b00, den_q};

		// shared multiplier operand select
		case (cw.mul)
			mpid_pkg::MUL_KI_T: begin
				mul_a = {2'b00, ki_q};
				mul_b = {2'b00, t_eff};
			end
			mpid_pkg::MUL_KP_ERR: begin
				mul_a = {2'b00, kp_q};
				mul_b = 33'(err_q);
			end
			mpid_pkg::MUL_KT_AVG: begin
				mul_a = {2'b00, kt_q};
				mul_b = 33'(avg_q);
			end
			mpid_pkg::MUL_KD_DM: begin
				mul_a = {2'b00, kd_q};
				mul_b = {1'b0, dm_mag_q};
			end
			mpid_pkg::MUL_C2_DP: begin
				mul_a = {1'b0, c2_mag_q};
				mul_b = {1'b0, dp_mag_q};
			end
			mpid_pkg::MUL_B1_LU: begin
				mul_a = {17'd0, mpid_pkg::PLANT_B1};
				mul_b = 33'(st.last_drive);
			end
			mpid_pkg::MUL_A1_LY: begin
				mul_a = {17'd0, mpid_pkg::PLANT_A1};
				mul_b = 33'(st.last_plant);
			end
			mpid_pkg::MUL_B0_U: begin
				mul_a = {17'd0, mpid_pkg::PLANT_B0};
				mul_b = 33'(u_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control: config, step counter, divider count, valid bits, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= mpid_pkg::RST_KP;
			ki_q        <= mpid_pkg::RST_KI;
			kd_q        <= mpid_pkg::RST_KD;
			tau_q       <= mpid_pkg::RST_TAU;
			ts_q        <= mpid_pkg::RST_TS;
			ilim_q      <= mpid_pkg::RST_ILIM;
			olim_q      <= mpid_pkg::RST_OLIM;
			busy_q      <= 1'b0;
			step_q      <= '0;
			div_cnt_q   <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpid_pkg::CFG_KP:   kp_q   <= cfg_data;
					mpid_pkg::CFG_KI:   ki_q   <= cfg_data;
					mpid_pkg::CFG_KD:   kd_q   <= cfg_data;
					mpid_pkg::CFG_TAU:  tau_q  <= cfg_data;
					mpid_pkg::CFG_TS:   ts_q   <= cfg_data;
					mpid_pkg::CFG_ILIM: ilim_q <= cfg_data;
					mpid_pkg::CFG_OLIM: olim_q <= cfg_data;
					default: ;
				endcase
			end

			// out-of-range channel: beat is dropped, sequencer stays idle
			if (accept && ch_ok) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				unique case (cw.seq)
					mpid_pkg::SEQ_NEXT: step_q <= step_q + 4'd1;
					mpid_pkg::SEQ_HOLD_DIV: begin
						if (!div_busy)
							step_q <= step_q + 4'd1;
					end
					mpid_pkg::SEQ_DONE: begin
						if (out_free) begin
							busy_q <= 1'b0;
							step_q <= '0;
						end
					end
					default: ;
				endcase
			end

			if (div_load)
				div_cnt_q <= mpid_pkg::DIV_STEPS;
			else if (div_busy)
				div_cnt_q <= div_cnt_q - 7'd1;

			if (fire_y)
				vld_q[ch_idx_q] <= 1'b1;

			if (fire_y)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// state memory: read on accept, written back when the result beat is loaded
	always_ff @(posedge clk) begin
		if (accept && ch_ok) begin
			st_rd_q  <= st_mem[idx];
			vld_rd_q <= vld_q[idx];
		end
		if (fire_y)
			st_mem[ch_idx_q] <= '{err_q, integ_q, d_q, ms_q, u_q, y_c};
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (accept) begin
			ch_idx_q <= idx;
			sp_q     <= setpoint;
			ms_q     <= measurement;
		end

		if (busy_q) begin
			unique case (cw.op)
				mpid_pkg::OP_PREP: begin
					err_q <= err_c;
					dm_q  <= dm_c;
					c2_q  <= c2_c;
					den_q <= den_c;
				end
				mpid_pkg::OP_KT: begin
					kt_q     <= kt_full[RW-1:0];
					avg_q    <= avg_rnd[32:1];
					dm_mag_q <= dm_mag_c;
					c2_mag_q <= c2_mag_c;
					dp_mag_q <= dp_mag_c;
				end
				mpid_pkg::OP_P:        p_q     <= p_c;
				mpid_pkg::OP_INTEG:    integ_q <= integ_c;
				mpid_pkg::OP_MA:       ma_q    <= {prod_q[62:0], 1'b0};
				mpid_pkg::OP_NUM: begin
					num_q <= num_c;
					nn_q  <= nn_c;
				end
				mpid_pkg::OP_D:        d_q     <= d_c;
				mpid_pkg::OP_U:        u_q     <= u_c;
				mpid_pkg::OP_ACC_LOAD: acc_q   <= prod_q[49:0];
				mpid_pkg::OP_ACC_ADD:  acc_q   <= acc_q + $signed(prod_q[49:0]);
				mpid_pkg::OP_Y: begin
					if (out_free) begin
						plant_q <= y_c;
						drive_q <= u_q;
					end
				end
				default: ;
			endcase
		end

		// one quotient bit per cycle
		if (div_load) begin
			quo_q <= dividend_c;
			rem_q <= '0;
		end else if (div_busy) begin
			if (!div_trial[34]) begin
				rem_q <= div_trial[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= div_shift[32:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// divider only runs while an item is in the sequencer
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !div_busy)
		else $error("divider running with sequencer idle");

	// quotient is consumed only after the divider has finished
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cw.op == mpid_pkg::OP_D) |-> !div_busy)
		else $error("derivative term taken from a running divider");

	// a result beat appears only out of the last microcode step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q && cw.seq == mpid_pkg::SEQ_DONE))
		else $error("result beat without the final step");

	// step counter stays inside the program
	a_step_rng: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < mpid_pkg::UC_LEN))
		else $error("step counter left the microcode program");

endmodule
